// ===== rtl/core/fgscc_pkg.sv =====
package fgscc_pkg;

  localparam int NODES  = 1024;
  localparam int DEGREE = 32;

  localparam int NW = $clog2(NODES);       // node index bits
  localparam int CW = NW + 1;              // counts that can reach NODES
  localparam int SW = $clog2(DEGREE);      // edge slot bits
  localparam int DW = $clog2(DEGREE + 1);  // degree bits

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 10;
  localparam int SLOT_W   = 5;
  localparam int DEG_IN_W = 6;
  localparam int OUT_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_NODE = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_MCLR,
    ST_IDLE,
    ST_SWEEP,
    ST_SW_TAIL,
    ST_OUTER_RD,
    ST_OUTER_CHK,
    ST_VISIT_ROOT,
    ST_VISIT_CHILD,
    ST_V_RD,
    ST_V_GET,
    ST_V_ATTR,
    ST_E_RD,
    ST_E_W,
    ST_E_CHK,
    ST_DESC,
    ST_FIN_RD,
    ST_FIN_P,
    ST_FIN_UPD,
    ST_POP_RD,
    ST_POP_CHK,
    ST_POP_END,
    ST_NEXT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic mclr;
    logic ld_node;
    logic ld_edge;
    logic out_ack;
    logic run_init;
    logic sweep;
    logic outer_rd;
    logic i_inc;
    logic visit;
    logic visit_child;
    logic v_get;
    logic v_attr;
    logic e_w;
    logic e_next;
    logic wb_low;
    logic fin_rd;
    logic fin_p;
    logic fin_upd;
    logic pop_rd;
    logic pop;
    logic scc_done;
    logic out_run;
  } ctrl_t;

  typedef struct packed {
    logic sweep_last;
    logic i_done;
    logic outer_take;
    logic e_end;
    logic w_desc;
    logic is_root;
    logic pop_more;
    logic walk_empty;
  } stat_t;

endpackage

// ===== rtl/core/fgscc_ctrl.sv =====
module fgscc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  fgscc_pkg::cmd_e       command_i,
  input  fgscc_pkg::stat_t      stat_i,
  output fgscc_pkg::ctrl_t      ctl_o,
  output logic                  busy_o
);
  import fgscc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MCLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_MCLR: begin
        ctl_o.mclr = 1'b1;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_NODE: begin
              ctl_o.ld_node = 1'b1;
              ctl_o.out_ack = 1'b1;
            end
            CMD_EDGE: begin
              ctl_o.ld_edge = 1'b1;
              ctl_o.out_ack = 1'b1;
            end
            CMD_RUN: begin
              ctl_o.run_init = 1'b1;
              state_d = ST_SWEEP;
            end
            default: ctl_o.out_ack = 1'b1;
          endcase
        end
      end
      ST_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = ST_SW_TAIL;
      end
      ST_SW_TAIL: state_d = ST_OUTER_RD;
      ST_OUTER_RD: begin
        if (stat_i.i_done) begin
          state_d = ST_FINISH;
        end else begin
          ctl_o.outer_rd = 1'b1;
          state_d = ST_OUTER_CHK;
        end
      end
      ST_OUTER_CHK: begin
        if (stat_i.outer_take) begin
          state_d = ST_VISIT_ROOT;
        end else begin
          ctl_o.i_inc = 1'b1;
          state_d = ST_OUTER_RD;
        end
      end
      ST_VISIT_ROOT: begin
        ctl_o.visit = 1'b1;
        state_d = ST_V_RD;
      end
      ST_VISIT_CHILD: begin
        ctl_o.visit       = 1'b1;
        ctl_o.visit_child = 1'b1;
        state_d = ST_V_RD;
      end
      ST_V_RD: state_d = ST_V_GET;
      ST_V_GET: begin
        ctl_o.v_get = 1'b1;
        state_d = ST_V_ATTR;
      end
      ST_V_ATTR: begin
        ctl_o.v_attr = 1'b1;
        state_d = ST_E_RD;
      end
      ST_E_RD: begin
        if (stat_i.e_end) begin
          state_d = ST_FIN_RD;
        end else begin
          state_d = ST_E_W;
        end
      end
      ST_E_W: begin
        ctl_o.e_w = 1'b1;
        state_d = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (stat_i.w_desc) begin
          state_d = ST_DESC;
        end else begin
          ctl_o.e_next = 1'b1;
          state_d = ST_E_RD;
        end
      end
      ST_DESC: begin
        ctl_o.wb_low = 1'b1;
        state_d = ST_VISIT_CHILD;
      end
      ST_FIN_RD: begin
        ctl_o.fin_rd = 1'b1;
        state_d = ST_FIN_P;
      end
      ST_FIN_P: begin
        ctl_o.fin_p = 1'b1;
        state_d = ST_FIN_UPD;
      end
      ST_FIN_UPD: begin
        ctl_o.fin_upd = 1'b1;
        state_d = stat_i.is_root ? ST_POP_RD : ST_NEXT;
      end
      ST_POP_RD: begin
        ctl_o.pop_rd = 1'b1;
        state_d = ST_POP_CHK;
      end
      ST_POP_CHK: begin
        ctl_o.pop = 1'b1;
        state_d = stat_i.pop_more ? ST_POP_RD : ST_POP_END;
      end
      ST_POP_END: begin
        ctl_o.scc_done = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (stat_i.walk_empty) begin
          ctl_o.i_inc = 1'b1;
          state_d = ST_OUTER_RD;
        end else begin
          state_d = ST_V_RD;
        end
      end
      ST_FINISH: begin
        ctl_o.out_run = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/fgscc_dp.sv =====
module fgscc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fgscc_pkg::ctrl_t                ctl_i,
  input  logic [fgscc_pkg::NODE_W-1:0]    node_i,
  input  logic [fgscc_pkg::SLOT_W-1:0]    slot_i,
  input  logic [fgscc_pkg::NODE_W-1:0]    neighbor_i,
  input  logic                            member_i,
  input  logic [fgscc_pkg::DEG_IN_W-1:0]  out_degree_i,
  output fgscc_pkg::stat_t                stat_o,
  output logic                            result_valid_o,
  output logic [fgscc_pkg::OUT_W-1:0]     scc_count_o,
  output logic [fgscc_pkg::OUT_W-1:0]     largest_scc_o,
  output logic [fgscc_pkg::OUT_W-1:0]     member_count_o,
  output logic                            done_res_o
);
  import fgscc_pkg::*;

  // Graph and walk memories.
  logic [NW-1:0] adj_mem   [NODES*DEGREE];
  logic [DW-1:0] deg_mem   [NODES];
  logic          mem_mem   [NODES];
  logic [CW-1:0] dn_mem    [NODES];
  logic [CW-1:0] low_mem   [NODES];
  logic [NW-1:0] par_mem   [NODES];
  logic          ons_mem   [NODES];
  logic [NW-1:0] walk_mem  [NODES];
  logic [NW-1:0] trace_mem [NODES];

  logic [NW-1:0] adj_rd_q, par_rd_q, walk_rd_q, trace_rd_q;
  logic [DW-1:0] deg_rd_q;
  logic          mem_rd_q, ons_rd_q;
  logic [CW-1:0] dn_rd_q, low_rd_q;

  logic [NW-1:0] sweep_q, v_q, w_q, p_q;
  logic [CW-1:0] i_q, wt_q, tt_q, counter_q, lowv_q, dnv_q, size_q;
  logic [CW-1:0] cnt_q, big_q, memb_q;
  logic [DW-1:0] e_q, d_q;
  logic          cnt_en_q;

  logic          res_valid_q, res_done_q;
  logic [OUT_W-1:0] res_cnt_q, res_big_q, res_memb_q;

  logic [NW-1:0] wt_idx, tt_idx, i_idx, visit_n, visit_from;
  logic [CW-1:0] next_num;
  logic [DW-1:0] deg_sat;
  logic          w_in_range;

  assign wt_idx     = wt_q[NW-1:0];
  assign tt_idx     = tt_q[NW-1:0];
  assign i_idx      = i_q[NW-1:0];
  assign visit_n    = ctl_i.visit_child ? w_q : i_idx;
  assign visit_from = ctl_i.visit_child ? v_q : i_idx;
  assign next_num   = counter_q + CW'(1);
  assign deg_sat    = (int'(out_degree_i) > DEGREE) ? DW'(DEGREE) : DW'(out_degree_i);
  assign w_in_range = (int'(w_q) < NODES);

  // Adjacency.
  logic          adj_we;
  logic [NW+SW-1:0] adj_wa, adj_ra;
  assign adj_we = ctl_i.ld_edge && (int'(node_i) < NODES) && (int'(slot_i) < DEGREE);
  assign adj_wa = {node_i[NW-1:0], slot_i[SW-1:0]};
  assign adj_ra = {v_q, e_q[SW-1:0]};
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= neighbor_i[NW-1:0];
    adj_rd_q <= adj_mem[adj_ra];
  end

  // Node attributes.
  logic node_we;
  assign node_we = ctl_i.ld_node && (int'(node_i) < NODES);

  logic [NW-1:0] attr_ra;
  always_comb begin
    priority if (ctl_i.v_get) attr_ra = walk_rd_q;
    else if (ctl_i.e_w)       attr_ra = adj_rd_q;
    else if (ctl_i.fin_p)     attr_ra = par_rd_q;
    else if (ctl_i.outer_rd)  attr_ra = i_idx;
    else                      attr_ra = sweep_q;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) deg_mem[node_i[NW-1:0]] <= deg_sat;
    deg_rd_q <= deg_mem[attr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      mem_mem[node_i[NW-1:0]] <= member_i;
    end else if (ctl_i.mclr) begin
      mem_mem[sweep_q] <= 1'b0;
    end
    mem_rd_q <= mem_mem[attr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep) begin
      dn_mem[sweep_q] <= '0;
    end else if (ctl_i.visit) begin
      dn_mem[visit_n] <= next_num;
    end
    dn_rd_q <= dn_mem[attr_ra];
  end

  logic          low_we;
  logic [NW-1:0] low_wa;
  logic [CW-1:0] low_wd;
  always_comb begin
    low_we = 1'b0;
    low_wa = v_q;
    low_wd = lowv_q;
    priority if (ctl_i.sweep) begin
      low_we = 1'b1;
      low_wa = sweep_q;
      low_wd = '0;
    end else if (ctl_i.visit) begin
      low_we = 1'b1;
      low_wa = visit_n;
      low_wd = next_num;
    end else if (ctl_i.wb_low || ctl_i.fin_rd) begin
      low_we = 1'b1;
    end else if (ctl_i.fin_upd) begin
      low_we = (lowv_q < low_rd_q);
      low_wa = p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[low_wa] <= low_wd;
    low_rd_q <= low_mem[attr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.visit) par_mem[visit_n] <= visit_from;
    par_rd_q <= par_mem[v_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep) begin
      ons_mem[sweep_q] <= 1'b0;
    end else if (ctl_i.visit) begin
      ons_mem[visit_n] <= 1'b1;
    end else if (ctl_i.pop) begin
      ons_mem[trace_rd_q] <= 1'b0;
    end
    ons_rd_q <= ons_mem[attr_ra];
  end

  // Both stacks are read one below their top.
  always_ff @(posedge clk_i) begin
    if (ctl_i.visit) walk_mem[wt_idx] <= visit_n;
    walk_rd_q <= walk_mem[wt_idx - NW'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.visit) trace_mem[tt_idx] <= visit_n;
    trace_rd_q <= trace_mem[tt_idx - NW'(1)];
  end

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      i_q       <= '0;
      wt_q      <= '0;
      tt_q      <= '0;
      counter_q <= '0;
      cnt_q     <= '0;
      big_q     <= '0;
      memb_q    <= '0;
      cnt_en_q  <= 1'b0;
    end else begin
      cnt_en_q <= ctl_i.sweep;
      if (ctl_i.mclr || ctl_i.sweep) sweep_q <= sweep_q + NW'(1);
      if (cnt_en_q && mem_rd_q) memb_q <= memb_q + CW'(1);
      if (ctl_i.run_init) begin
        sweep_q   <= '0;
        i_q       <= '0;
        wt_q      <= '0;
        tt_q      <= '0;
        counter_q <= '0;
        cnt_q     <= '0;
        big_q     <= '0;
        memb_q    <= '0;
      end
      if (ctl_i.i_inc) i_q <= i_q + CW'(1);
      if (ctl_i.visit) begin
        wt_q      <= wt_q + CW'(1);
        tt_q      <= tt_q + CW'(1);
        counter_q <= next_num;
      end
      if (ctl_i.fin_rd) wt_q <= wt_q - CW'(1);
      if (ctl_i.pop_rd) tt_q <= tt_q - CW'(1);
      if (ctl_i.scc_done) begin
        cnt_q <= cnt_q + CW'(1);
        if (size_q > big_q) big_q <= size_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.v_get) begin
      v_q <= walk_rd_q;
      e_q <= '0;
    end
    if (ctl_i.v_attr) begin
      d_q    <= deg_rd_q;
      lowv_q <= low_rd_q;
      dnv_q  <= dn_rd_q;
    end
    if (ctl_i.e_w) w_q <= adj_rd_q;
    if (ctl_i.e_next) begin
      e_q <= e_q + DW'(1);
      if (w_in_range && mem_rd_q && ons_rd_q && (dn_rd_q < lowv_q)) lowv_q <= dn_rd_q;
    end
    if (ctl_i.fin_p) p_q <= par_rd_q;
    if (ctl_i.fin_upd) size_q <= '0;
    if (ctl_i.pop) size_q <= size_q + CW'(1);
  end

  // Result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.out_ack || ctl_i.out_run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_run) begin
      res_cnt_q  <= OUT_W'(cnt_q);
      res_big_q  <= OUT_W'(big_q);
      res_memb_q <= OUT_W'(memb_q);
      res_done_q <= 1'b1;
    end else if (ctl_i.out_ack) begin
      res_cnt_q  <= '0;
      res_big_q  <= '0;
      res_memb_q <= '0;
      res_done_q <= 1'b0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign scc_count_o    = res_cnt_q;
  assign largest_scc_o  = res_big_q;
  assign member_count_o = res_memb_q;
  assign done_res_o     = res_done_q;

  assign stat_o.sweep_last = (sweep_q == NW'(NODES - 1));
  assign stat_o.i_done     = (int'(i_q) >= NODES);
  assign stat_o.outer_take = mem_rd_q && (dn_rd_q == '0);
  assign stat_o.e_end      = (e_q >= d_q);
  assign stat_o.w_desc     = w_in_range && mem_rd_q && (dn_rd_q == '0);
  assign stat_o.is_root    = (lowv_q == dnv_q);
  assign stat_o.pop_more   = (trace_rd_q != v_q) && (tt_q != '0);
  assign stat_o.walk_empty = (wt_q == '0);

endmodule

// ===== rtl/core/filtered_graph_scc_count.sv =====
// Channel   Handshake                 Payload
// command   start_i / busy_o          command_i node_i slot_i neighbor_i member_i out_degree_i
// result    result_valid_o (1 cycle)  scc_count_o largest_scc_o member_count_o done_res_o
//
// After reset the member flags are cleared in a pass over all NODES entries with busy_o high.
// Node and edge loads are accepted while idle; their result beat is on the ports in the cycle
// after the accepting edge and busy_o stays low, so loads can be issued every cycle.
// A run sweeps the walk tables and then scans every node. After each descent the parent
// is fetched again and rescans its edges. The result beat lasts one cycle and the receiver
// cannot stall it.
module filtered_graph_scc_count (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [fgscc_pkg::CMD_W-1:0]     command_i,
  input  logic [fgscc_pkg::NODE_W-1:0]    node_i,
  input  logic [fgscc_pkg::SLOT_W-1:0]    slot_i,
  input  logic [fgscc_pkg::NODE_W-1:0]    neighbor_i,
  input  logic                            member_i,
  input  logic [fgscc_pkg::DEG_IN_W-1:0]  out_degree_i,
  output logic                            result_valid_o,
  output logic [fgscc_pkg::OUT_W-1:0]     scc_count_o,
  output logic [fgscc_pkg::OUT_W-1:0]     largest_scc_o,
  output logic [fgscc_pkg::OUT_W-1:0]     member_count_o,
  output logic                            done_res_o
);
  import fgscc_pkg::*;

  ctrl_t ctl;
  stat_t stat;
  cmd_e  cmd;

  assign cmd = cmd_e'(command_i);

  fgscc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (cmd),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy_o    (busy_o)
  );

  fgscc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .node_i         (node_i),
    .slot_i         (slot_i),
    .neighbor_i     (neighbor_i),
    .member_i       (member_i),
    .out_degree_i   (out_degree_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .scc_count_o    (scc_count_o),
    .largest_scc_o  (largest_scc_o),
    .member_count_o (member_count_o),
    .done_res_o     (done_res_o)
  );

endmodule

// ===== tb/tb_filtered_graph_scc_count.sv =====
module tb_filtered_graph_scc_count;
  import fgscc_pkg::*;

  typedef struct packed {
    cmd_e                  cmd;
    logic [NODE_W-1:0]     node;
    logic [SLOT_W-1:0]     slot;
    logic [NODE_W-1:0]     nbr;
    logic                  member;
    logic [DEG_IN_W-1:0]   degree;
  } load_t;

  typedef struct packed {
    logic [OUT_W-1:0] scc_count;
    logic [OUT_W-1:0] largest;
    logic [OUT_W-1:0] members;
    logic             done;
  } tally_t;

  typedef struct packed {
    load_t  cmd_beat;
    logic   typed;
    tally_t tally;
  } row_t;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 500;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [CMD_W-1:0]      command_i = '0;
  logic [NODE_W-1:0]     node_i = '0;
  logic [SLOT_W-1:0]     slot_i = '0;
  logic [NODE_W-1:0]     neighbor_i = '0;
  logic                  member_i = 1'b0;
  logic [DEG_IN_W-1:0]   out_degree_i = '0;
  logic                  result_valid_o;
  logic [OUT_W-1:0]      scc_count_o;
  logic [OUT_W-1:0]      largest_scc_o;
  logic [OUT_W-1:0]      member_count_o;
  logic                  done_res_o;

  filtered_graph_scc_count u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .node_i, .slot_i,
    .neighbor_i, .member_i, .out_degree_i, .result_valid_o, .scc_count_o,
    .largest_scc_o, .member_count_o, .done_res_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the graph tables.
  logic [NODE_W-1:0] edge_tbl [NODES][DEGREE];
  bit                edge_written [NODES][DEGREE];
  int                degree_tbl [NODES];
  bit                member_tbl [NODES];

  tally_t tally_q[$];
  int     errors = 0;
  int     quiet_cycles = 0;
  int     burst_left = 0;

  function automatic tally_t count_components();
    int     disc [NODES];
    int     low [NODES];
    int     par [NODES];
    bit     onst [NODES];
    int     walk [NODES];
    int     trace [NODES];
    int     wtop, ttop, visits, cnt, big, mcount, v, w, d, p, sz;
    bit     went_down;
    tally_t t;
    wtop = 0; ttop = 0; visits = 0; cnt = 0; big = 0; mcount = 0;
    for (int i = 0; i < NODES; i++) begin
      disc[i] = 0; low[i] = 0; onst[i] = 0;
      if (member_tbl[i]) mcount++;
    end
    for (int i = 0; i < NODES; i++) begin
      if (!member_tbl[i] || disc[i] != 0) continue;
      walk[wtop] = i; wtop++; trace[ttop] = i; ttop++; par[i] = i;
      visits++; disc[i] = visits; low[i] = visits; onst[i] = 1;
      while (wtop > 0) begin
        v = walk[wtop-1];
        d = degree_tbl[v];
        went_down = 0;
        for (int e = 0; e < d; e++) begin
          w = edge_tbl[v][e];
          if (!member_tbl[w]) continue;
          if (disc[w] == 0) begin
            walk[wtop] = w; wtop++; trace[ttop] = w; ttop++; par[w] = v;
            visits++; disc[w] = visits; low[w] = visits; onst[w] = 1;
            went_down = 1;
            break;
          end
          if (onst[w] && disc[w] < low[v]) low[v] = disc[w];
        end
        if (!went_down) begin
          p = par[v];
          wtop--;
          if (low[v] < low[p]) low[p] = low[v];
          if (low[v] == disc[v]) begin
            sz = 0;
            do begin
              ttop--;
              w = trace[ttop];
              onst[w] = 0;
              sz++;
            end while (w != v && ttop > 0);
            cnt++;
            if (sz > big) big = sz;
          end
        end
      end
    end
    t.scc_count = cnt[OUT_W-1:0];
    t.largest   = big[OUT_W-1:0];
    t.members   = mcount[OUT_W-1:0];
    t.done      = 1'b1;
    return t;
  endfunction

  function automatic tally_t apply_beat(load_t b);
    tally_t t;
    t = '0;
    case (b.cmd)
      CMD_NODE: begin
        member_tbl[b.node] = b.member;
        degree_tbl[b.node] = (b.degree > DEGREE) ? DEGREE : int'(b.degree);
      end
      CMD_EDGE: begin
        edge_tbl[b.node][b.slot] = b.nbr;
        edge_written[b.node][b.slot] = 1;
      end
      CMD_RUN:  t = count_components();
      default:  ;
    endcase
    return t;
  endfunction

  function automatic int written_prefix(int n);
    int k;
    k = 0;
    while (k < DEGREE && edge_written[n][k]) k++;
    return k;
  endfunction

  task automatic issue(load_t b, bit typed, tally_t typed_tally);
    tally_t t;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        start_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    start_i      = 1'b1;
    command_i    = b.cmd;
    node_i       = b.node;
    slot_i       = b.slot;
    neighbor_i   = b.nbr;
    member_i     = b.member;
    out_degree_i = b.degree;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    quiet_cycles = 0;
    t = apply_beat(b);
    tally_q.insert(tally_q.size(), typed ? typed_tally : t);
  endtask

  function automatic load_t make_beat(cmd_e c, int n, int s, int nb, bit m, int d);
    load_t b;
    b.cmd = c;
    b.node = NODE_W'(n);
    b.slot = SLOT_W'(s);
    b.nbr = NODE_W'(nb);
    b.member = m;
    b.degree = DEG_IN_W'(d);
    return b;
  endfunction

  // Result beats cannot be stalled, so they are checked as they appear.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      quiet_cycles = 0;
      if (tally_q.size() == 0) begin
        $display("%0t: unexpected result beat: count %0d largest %0d members %0d done %0b",
                 $time, scc_count_o, largest_scc_o, member_count_o, done_res_o);
        errors++;
      end else begin
        tally_t x;
        x = tally_q.pop_front();
        if (scc_count_o !== x.scc_count) begin
          $display("%0t: scc_count expected %0d actual %0d", $time, x.scc_count, scc_count_o);
          errors++;
        end
        if (largest_scc_o !== x.largest) begin
          $display("%0t: largest_scc expected %0d actual %0d", $time, x.largest, largest_scc_o);
          errors++;
        end
        if (member_count_o !== x.members) begin
          $display("%0t: member_count expected %0d actual %0d", $time, x.members,
                   member_count_o);
          errors++;
        end
        if (done_res_o !== x.done) begin
          $display("%0t: done_res expected %0b actual %0b", $time, x.done, done_res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("** filtered_graph_scc_count: FAILED **");
      $finish;
    end
  end

  row_t rows [$];

  initial begin
    int     items, pool_n, k, d, n;
    int     pool [16];
    tally_t zero_ack;
    tally_t empty_run;
    zero_ack = '0;
    empty_run = '0;
    empty_run.done = 1'b1;
    for (int i = 0; i < NODES; i++) begin
      degree_tbl[i] = 0; member_tbl[i] = 0;
      for (int j = 0; j < DEGREE; j++) begin
        edge_tbl[i][j] = '0; edge_written[i][j] = 0;
      end
    end

    rows = '{
      '{make_beat(CMD_RUN, 0, 0, 0, 0, 0), 1'b1, empty_run},
      '{make_beat(CMD_NONE, 1023, 31, 1023, 1, 63), 1'b1, zero_ack},
      '{make_beat(CMD_EDGE, 1023, 31, 1023, 1, 63), 1'b1, zero_ack},
      '{make_beat(CMD_EDGE, 1023, 0, 1023, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 1023, 0, 0, 1, 1), 1'b1, zero_ack},
      '{make_beat(CMD_RUN, 0, 0, 0, 0, 0), 1'b1, '{11'd1, 11'd1, 11'd1, 1'b1}},
      '{make_beat(CMD_EDGE, 0, 0, 1, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_EDGE, 1, 0, 2, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_EDGE, 2, 0, 0, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_EDGE, 2, 1, 1023, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 0, 0, 0, 1, 1), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 1, 0, 0, 1, 1), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 2, 0, 0, 1, 2), 1'b1, zero_ack},
      '{make_beat(CMD_RUN, 0, 0, 0, 0, 0), 1'b0, zero_ack},
      '{make_beat(CMD_NODE, 2, 0, 0, 0, 63), 1'b1, zero_ack},
      '{make_beat(CMD_RUN, 0, 0, 0, 0, 0), 1'b0, zero_ack},
      '{make_beat(CMD_NODE, 0, 0, 0, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 1, 0, 0, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_NODE, 1023, 0, 0, 0, 0), 1'b1, zero_ack},
      '{make_beat(CMD_RUN, 0, 0, 0, 0, 0), 1'b1, empty_run}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) issue(rows[i].cmd_beat, rows[i].typed, rows[i].tally);

    // Most of the random part builds small subgraphs and then runs a search;
    // the rest is loose traffic.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: issue(make_beat(CMD_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                             $urandom), 1'b0, zero_ack);
          1: issue(make_beat(CMD_NODE, $urandom, $urandom, $urandom, 0, $urandom),
                   1'b0, zero_ack);
          default: issue(make_beat(CMD_EDGE, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 1), $urandom), 1'b0, zero_ack);
        endcase
        items++;
      end else begin
        pool_n = $urandom_range(2, 12);
        n = $urandom_range(0, NODES - 16);
        for (int i = 0; i < pool_n; i++)
          pool[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1)
                                                 : n + $urandom_range(0, 15);
        for (int i = 0; i < pool_n; i++) begin
          k = ($urandom_range(0, 15) == 0) ? DEGREE : $urandom_range(0, 4);
          for (int s = 0; s < k; s++) begin
            issue(make_beat(CMD_EDGE, pool[i], s,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(0, NODES - 1)
                                                        : pool[$urandom_range(0, pool_n - 1)],
                            $urandom_range(0, 1), $urandom), 1'b0, zero_ack);
            items++;
          end
        end
        for (int i = 0; i < pool_n; i++) begin
          k = written_prefix(pool[i]);
          if (k == DEGREE && $urandom_range(0, 1)) d = $urandom_range(DEGREE, 63);
          else d = $urandom_range(0, k);
          issue(make_beat(CMD_NODE, pool[i], $urandom, $urandom,
                          $urandom_range(0, 5) != 0, d), 1'b0, zero_ack);
          items++;
        end
        issue(make_beat(CMD_RUN, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                        $urandom), 1'b0, zero_ack);
        items++;
      end
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** filtered_graph_scc_count: PASSED **");
    end else begin
      $display("** filtered_graph_scc_count: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filtered_graph_scc_count.f =====
rtl/core/fgscc_pkg.sv
rtl/core/fgscc_ctrl.sv
rtl/core/fgscc_dp.sv
rtl/core/filtered_graph_scc_count.sv
tb/tb_filtered_graph_scc_count.sv
